// ----- rtl/acce_pkg.sv -----
// Shared types and constants for the adaptive command code encoder.
`timescale 1ns / 1ps

package acce_pkg;

	localparam int NUM_CODES = 32;
	localparam int CODE_W    = 5;
	localparam int TALLY_W   = 7;
	localparam int LEN_W     = 4;
	localparam int MODE_W    = 3;
	localparam int SIZE_W    = 10;  // coded size of up to 101 codes at 8 bits

	// coding modes
	localparam logic [MODE_W-1:0] MODE_PLAIN = 3'd1;
	localparam logic [MODE_W-1:0] MODE_FAV1  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_FAV2  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_FAV3  = 3'd4;

	localparam logic [LEN_W-1:0] LEN_PLAIN = 4'd5;
	localparam logic [LEN_W-1:0] LEN_ESC1  = 4'd6;
	localparam logic [LEN_W-1:0] LEN_ESC2  = 4'd7;
	localparam logic [LEN_W-1:0] LEN_ESC3  = 4'd8;
	localparam logic [LEN_W-1:0] LEN_HIT1  = 4'd1;
	localparam logic [LEN_W-1:0] LEN_HIT2  = 4'd2;
	localparam logic [LEN_W-1:0] LEN_HIT3  = 4'd3;
	localparam logic [CODE_W-1:0] PAT_HIT  = 5'd1;

	// adaptation thresholds per warmup phase
	localparam logic [TALLY_W-1:0] THR_PHASE0 = 7'd5;
	localparam logic [TALLY_W-1:0] THR_PHASE1 = 7'd20;
	localparam logic [TALLY_W-1:0] THR_PHASE2 = 7'd100;

	localparam logic [1:0] PHASE_FIRST  = 2'd0;
	localparam logic [1:0] PHASE_SECOND = 2'd1;
	localparam logic [1:0] PHASE_STEADY = 2'd2;

	localparam logic [CODE_W-1:0] RESET_FAV1 = 5'd17;
	localparam logic [CODE_W-1:0] RESET_FAV2 = 5'd18;
	localparam logic [CODE_W-1:0] RESET_FAV3 = 5'd19;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RMW,
		ST_SCAN,
		ST_DRAIN,
		ST_DECIDE
	} state_t;

	// access to the tally memory
	typedef struct packed {
		logic              rd_en;
		logic              rd_clr;   // drop the entry once read
		logic [CODE_W-1:0] rd_addr;
		logic              wr_en;
		logic [CODE_W-1:0] wr_addr;
		logic [TALLY_W-1:0] wr_data;
	} tally_req_t;

	// top three codes and total from one scan
	typedef struct packed {
		logic [CODE_W-1:0]  c1;
		logic [CODE_W-1:0]  c2;
		logic [CODE_W-1:0]  c3;
		logic [TALLY_W-1:0] n1;
		logic [TALLY_W-1:0] n2;
		logic [TALLY_W-1:0] n3;
		logic [TALLY_W-1:0] total;
	} rank_t;

endpackage

// ----- rtl/acce_tally.sv -----
// Per-code tally memory with registered read and per-entry valid flags.
`timescale 1ns / 1ps

module acce_tally
	import acce_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  tally_req_t         req,
	output logic [TALLY_W-1:0] rd_data
);

	logic [TALLY_W-1:0] mem [NUM_CODES];
	logic [NUM_CODES-1:0] valid_q;
	logic [TALLY_W-1:0] rd_data_q;

	// an entry never written since reset or since its last scan reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (req.rd_en && req.rd_clr)
				valid_q[req.rd_addr] <= 1'b0;
			if (req.wr_en)
				valid_q[req.wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.wr_en)
			mem[req.wr_addr] <= req.wr_data;
		if (req.rd_en)
			rd_data_q <= valid_q[req.rd_addr] ? mem[req.rd_addr] : '0;
	end

	assign rd_data = rd_data_q;

endmodule

// ----- rtl/acce_rank.sv -----
// Running top-three and total over the tallies streamed out during a scan.
`timescale 1ns / 1ps

module acce_rank
	import acce_pkg::*;
(
	input  logic               clk,
	input  logic               start,
	input  logic               in_valid,
	input  logic [CODE_W-1:0]  in_code,
	input  logic [TALLY_W-1:0] in_cnt,
	output rank_t              rank
);

	rank_t rank_q;

	// strictly greater displaces, so the earlier code keeps a tie
	always_ff @(posedge clk) begin
		if (start) begin
			rank_q.c1    <= 5'd0;
			rank_q.c2    <= 5'd1;
			rank_q.c3    <= 5'd2;
			rank_q.n1    <= '0;
			rank_q.n2    <= '0;
			rank_q.n3    <= '0;
			rank_q.total <= '0;
		end else if (in_valid) begin
			rank_q.total <= rank_q.total + in_cnt;
			if (in_cnt > rank_q.n3) begin
				if (in_cnt > rank_q.n1) begin
					rank_q.c3 <= rank_q.c2;
					rank_q.n3 <= rank_q.n2;
					rank_q.c2 <= rank_q.c1;
					rank_q.n2 <= rank_q.n1;
					rank_q.c1 <= in_code;
					rank_q.n1 <= in_cnt;
				end else if (in_cnt > rank_q.n2) begin
					rank_q.c3 <= rank_q.c2;
					rank_q.n3 <= rank_q.n2;
					rank_q.c2 <= in_code;
					rank_q.n2 <= in_cnt;
				end else begin
					rank_q.c3 <= in_code;
					rank_q.n3 <= in_cnt;
				end
			end
		end
	end

	assign rank = rank_q;

endmodule

// ----- rtl/adaptive_command_code_encoder_core.sv -----
// Top level of the adaptive command code encoder: encoding, tally control, mode choice.
`timescale 1ns / 1ps

// Each request carries one 5-bit command code and yields one result: a right-aligned
// bit pattern and its length (1 to 8) under the coding mode in force before that code.
// For each code the tally entry is read from the memory, then written back incremented,
// and the next request is taken after that. After the 6th, then the 21st, then every
// 101st code since the last change, the block scans all 32 tallies through the memory
// read port (one per cycle), waits in ST_DRAIN for the last read and chooses the mode
// in ST_DECIDE. The tallies need no clearing pass after reset: per-entry valid flags
// make unwritten entries read as zero. The single result register holds one result;
// a new request is taken only while it is empty or its result leaves in the same cycle.

module adaptive_command_code_encoder_core
	import acce_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [4:0] code_in
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata    // [4:0] bit_pattern, [8:5] bit_length
);

	state_t state_q, state_d;

	logic [MODE_W-1:0]  mode_q;
	logic [CODE_W-1:0]  fav1_q, fav2_q, fav3_q;
	logic [TALLY_W-1:0] cnt_q;
	logic [1:0]         phase_q;

	logic [CODE_W-1:0]  code_q;
	logic [CODE_W-1:0]  scan_idx_q;
	logic               scan_vld_s1;
	logic [CODE_W-1:0]  scan_code_s1;

	logic               out_valid_q;
	logic [CODE_W-1:0]  out_pat_q;
	logic [LEN_W-1:0]   out_len_q;

	logic               accept;
	logic [CODE_W-1:0]  code_in;
	logic [CODE_W-1:0]  enc_pat;
	logic [LEN_W-1:0]   enc_len;

	tally_req_t         treq;
	logic [TALLY_W-1:0] tally_rd;
	logic               rank_start;
	rank_t              rank;

	logic [TALLY_W-1:0] cnt_next;
	logic               adapt;

	logic [SIZE_W-1:0]  tot_w, n1_w, n2_w, n3_w;
	logic [SIZE_W-1:0]  sz1, sz2, sz3, sz4;

	assign code_in       = s_axis_tdata[CODE_W-1:0];
	assign s_axis_tready = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'b0, out_len_q, out_pat_q};

	// encoding under the current mode; an out-of-range mode acts as three favorites
	always_comb begin
		enc_pat = code_in;
		enc_len = LEN_ESC3;
		unique case (mode_q)
			MODE_PLAIN: begin
				enc_len = LEN_PLAIN;
			end
			MODE_FAV1: begin
				if (code_in == fav1_q) begin
					enc_pat = PAT_HIT;
					enc_len = LEN_HIT1;
				end else begin
					enc_len = LEN_ESC1;
				end
			end
			MODE_FAV2: begin
				if (code_in == fav1_q) begin
					enc_pat = PAT_HIT;
					enc_len = LEN_HIT1;
				end else if (code_in == fav2_q) begin
					enc_pat = PAT_HIT;
					enc_len = LEN_HIT2;
				end else begin
					enc_len = LEN_ESC2;
				end
			end
			default: begin
				if (code_in == fav1_q) begin
					enc_pat = PAT_HIT;
					enc_len = LEN_HIT1;
				end else if (code_in == fav2_q) begin
					enc_pat = PAT_HIT;
					enc_len = LEN_HIT2;
				end else if (code_in == fav3_q) begin
					enc_pat = PAT_HIT;
					enc_len = LEN_HIT3;
				end else begin
					enc_len = LEN_ESC3;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (accept)
			out_valid_q <= 1'b1;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_pat_q <= enc_pat;
			out_len_q <= enc_len;
			code_q    <= code_in;
		end
	end

	assign cnt_next = cnt_q + 7'd1;

	always_comb begin
		unique case (phase_q)
			PHASE_FIRST:  adapt = cnt_next > THR_PHASE0;
			PHASE_SECOND: adapt = cnt_next > THR_PHASE1;
			PHASE_STEADY: adapt = cnt_next > THR_PHASE2;
			default:      adapt = 1'b0;
		endcase
	end

	// coded size of the last window under each mode
	assign tot_w = SIZE_W'(rank.total);
	assign n1_w  = SIZE_W'(rank.n1);
	assign n2_w  = SIZE_W'(rank.n2);
	assign n3_w  = SIZE_W'(rank.n3);
	assign sz1   = tot_w * 10'd5;
	assign sz2   = n1_w + (tot_w - n1_w) * 10'd6;
	assign sz3   = n1_w + n2_w * 10'd2 + (tot_w - n1_w - n2_w) * 10'd7;
	assign sz4   = n1_w + n2_w * 10'd2 + n3_w * 10'd3
		+ (tot_w - n1_w - n2_w - n3_w) * 10'd8;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// next state and memory requests
	always_comb begin
		state_d      = state_q;
		treq         = '0;
		rank_start   = 1'b0;
		treq.rd_addr = code_in;
		treq.wr_addr = code_q;
		treq.wr_data = tally_rd + 7'd1;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					treq.rd_en = 1'b1;
					state_d    = ST_RMW;
				end
			end
			ST_RMW: begin
				treq.wr_en = 1'b1;
				if (adapt) begin
					rank_start = 1'b1;
					state_d    = ST_SCAN;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_SCAN: begin
				treq.rd_en   = 1'b1;
				treq.rd_clr  = 1'b1;
				treq.rd_addr = scan_idx_q;
				if (scan_idx_q == CODE_W'(NUM_CODES - 1))
					state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q  <= '0;
			scan_vld_s1 <= 1'b0;
		end else begin
			scan_vld_s1 <= (state_q == ST_SCAN);
			if (state_q == ST_SCAN)
				scan_idx_q <= scan_idx_q + 5'd1;
			else
				scan_idx_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		scan_code_s1 <= scan_idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_FAV3;
			fav1_q  <= RESET_FAV1;
			fav2_q  <= RESET_FAV2;
			fav3_q  <= RESET_FAV3;
			cnt_q   <= '0;
			phase_q <= PHASE_FIRST;
		end else begin
			if (state_q == ST_RMW) begin
				if (adapt) begin
					cnt_q <= '0;
					if (phase_q == PHASE_FIRST)
						phase_q <= PHASE_SECOND;
					else if (phase_q == PHASE_SECOND)
						phase_q <= PHASE_STEADY;
				end else begin
					cnt_q <= cnt_next;
				end
			end
			// lower mode wins on equal size
			if (state_q == ST_DECIDE) begin
				if (sz1 <= sz2 && sz1 <= sz3 && sz1 <= sz4) begin
					mode_q <= MODE_PLAIN;
				end else if (sz2 <= sz3 && sz2 <= sz4) begin
					mode_q <= MODE_FAV1;
					fav1_q <= rank.c1;
				end else if (sz3 <= sz4) begin
					mode_q <= MODE_FAV2;
					fav1_q <= rank.c1;
					fav2_q <= rank.c2;
				end else begin
					mode_q <= MODE_FAV3;
					fav1_q <= rank.c1;
					fav2_q <= rank.c2;
					fav3_q <= rank.c3;
				end
			end
		end
	end

	acce_tally u_tally (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (treq),
		.rd_data (tally_rd)
	);

	acce_rank u_rank (
		.clk      (clk),
		.start    (rank_start),
		.in_valid (scan_vld_s1),
		.in_code  (scan_code_s1),
		.in_cnt   (tally_rd),
		.rank     (rank)
	);

	a_accept_rmw: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_RMW)
		else $error("accepted request not followed by tally write-back");

	a_mode_range: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q != 3'd0 && mode_q <= MODE_FAV3)
		else $error("coding mode out of range");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= THR_PHASE2)
		else $error("since-adapt counter past its limit");

	a_scan_closed: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN || state_q == ST_DRAIN || state_q == ST_DECIDE)
			|-> !s_axis_tready)
		else $error("request taken during adaptation");

endmodule

// ----- tb/adaptive_command_code_encoder_core_tb.sv -----
// Self-checking testbench for the adaptive command code encoder core.
`timescale 1ns / 1ps

module adaptive_command_code_encoder_core_tb;
	import acce_pkg::*;

	localparam int N_RANDOM     = 1000;
	localparam int IDLE_LIMIT   = 2000;  // cycles with no request or result accepted
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 50;

	typedef struct packed {
		logic [CODE_W-1:0] pat;
		logic [LEN_W-1:0]  len;
	} code_word_t;

	// one request; has_word marks a hand-written expected code word
	typedef struct packed {
		bit                has_word;
		logic [CODE_W-1:0] code;
		code_word_t        word;
	} code_row_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;    // [4:0] code_in
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;         // [4:0] bit_pattern, [8:5] bit_length

	adaptive_command_code_encoder_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// encoder state as the predictor sees it
	logic [MODE_W-1:0]  cur_mode;
	logic [CODE_W-1:0]  fav1, fav2, fav3;
	logic [TALLY_W-1:0] since_cnt;
	logic [1:0]         phase;
	logic [TALLY_W-1:0] tally [NUM_CODES];

	code_row_t  offered_q [$];
	code_word_t code_word_q [$];
	int         errors = 0;
	bit         src_gaps_on = 1'b1;
	bit         sink_stalls_on = 1'b1;
	bit         hold_req = 1'b0;

	// code word under the current mode, then tally and maybe re-rank
	function automatic code_word_t encode_code(input logic [CODE_W-1:0] code);
		code_word_t w;
		logic adapt;
		int i, n, total, n1, n2, n3, s1, s2, s3, s4, best;
		logic [CODE_W-1:0] c1, c2, c3;
		w.pat = code;
		case (cur_mode)
			MODE_PLAIN: w.len = LEN_PLAIN;
			MODE_FAV1: begin
				if (code == fav1) w = '{PAT_HIT, LEN_HIT1};
				else w.len = LEN_ESC1;
			end
			MODE_FAV2: begin
				if (code == fav1) w = '{PAT_HIT, LEN_HIT1};
				else if (code == fav2) w = '{PAT_HIT, LEN_HIT2};
				else w.len = LEN_ESC2;
			end
			default: begin
				if (code == fav1) w = '{PAT_HIT, LEN_HIT1};
				else if (code == fav2) w = '{PAT_HIT, LEN_HIT2};
				else if (code == fav3) w = '{PAT_HIT, LEN_HIT3};
				else w.len = LEN_ESC3;
			end
		endcase
		since_cnt = since_cnt + TALLY_W'(1);
		tally[code] = tally[code] + TALLY_W'(1);
		adapt = 1'b0;
		case (phase)
			PHASE_FIRST: begin
				if (since_cnt > THR_PHASE0) begin
					phase = PHASE_SECOND;
					adapt = 1'b1;
				end
			end
			PHASE_SECOND: begin
				if (since_cnt > THR_PHASE1) begin
					phase = PHASE_STEADY;
					adapt = 1'b1;
				end
			end
			PHASE_STEADY: adapt = (since_cnt > THR_PHASE2);
			default: ;
		endcase
		if (adapt) begin
			c1 = 5'd0; c2 = 5'd1; c3 = 5'd2;
			n1 = 0; n2 = 0; n3 = 0; total = 0;
			// strict compares: earlier code keeps its rank on a tie
			for (i = 0; i < NUM_CODES; i++) begin
				n = int'(tally[i]);
				tally[i] = '0;
				total += n;
				if (n > n3) begin
					if (n > n1) begin
						c3 = c2; n3 = n2;
						c2 = c1; n2 = n1;
						c1 = CODE_W'(i); n1 = n;
					end else if (n > n2) begin
						c3 = c2; n3 = n2;
						c2 = CODE_W'(i); n2 = n;
					end else begin
						c3 = CODE_W'(i); n3 = n;
					end
				end
			end
			s1 = total * 5;
			s2 = n1 + (total - n1) * 6;
			s3 = n1 + n2 * 2 + (total - n1 - n2) * 7;
			s4 = n1 + n2 * 2 + n3 * 3 + (total - n1 - n2 - n3) * 8;
			best = s1;
			if (s2 < best) best = s2;
			if (s3 < best) best = s3;
			if (s4 < best) best = s4;
			// lower mode wins equal sizes; only the favorites in use are rewritten
			if (best == s1) begin
				cur_mode = MODE_PLAIN;
			end else if (best == s2) begin
				cur_mode = MODE_FAV1;
				fav1 = c1;
			end else if (best == s3) begin
				cur_mode = MODE_FAV2;
				fav1 = c1; fav2 = c2;
			end else begin
				cur_mode = MODE_FAV3;
				fav1 = c1; fav2 = c2; fav3 = c3;
			end
			since_cnt = '0;
		end
		return w;
	endfunction

	// out of reset: favorites 17/18/19 in three-favorite mode; the sixth code
	// re-ranks to plain mode (all counts 1, plain ties three-favorite at 30 bits)
	code_row_t dir_tbl [20] = '{
		'{1'b1, 5'd17, '{PAT_HIT, LEN_HIT1}},
		'{1'b1, 5'd18, '{PAT_HIT, LEN_HIT2}},
		'{1'b1, 5'd19, '{PAT_HIT, LEN_HIT3}},
		'{1'b1, 5'd0,  '{5'd0,    LEN_ESC3}},
		'{1'b1, 5'd31, '{5'd31,   LEN_ESC3}},
		'{1'b1, 5'd5,  '{5'd5,    LEN_ESC3}},
		'{1'b1, 5'd0,  '{5'd0,    LEN_PLAIN}},
		'{1'b1, 5'd31, '{5'd31,   LEN_PLAIN}},
		'{1'b1, 5'd17, '{5'd17,   LEN_PLAIN}},
		'{1'b0, 5'd9,  '0},
		'{1'b0, 5'd9,  '0},
		'{1'b0, 5'd9,  '0},
		'{1'b0, 5'd9,  '0},
		'{1'b0, 5'd9,  '0},
		'{1'b0, 5'd9,  '0},
		'{1'b0, 5'd9,  '0},
		'{1'b0, 5'd14, '0},
		'{1'b0, 5'd9,  '0},
		'{1'b0, 5'd21, '0},
		'{1'b0, 5'd9,  '0}
	};

	task automatic send_code(input code_row_t row);
		int gap;
		gap = 0;
		if (src_gaps_on && $urandom_range(0, 99) >= 60)
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 3);
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		offered_q.push_back(row);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {3'b000, row.code};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// request capture and result check
	always @(posedge clk) begin : scoreboard
		code_row_t  row;
		code_word_t want;
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			row = offered_q.pop_front();
			want = encode_code(row.code);
			code_word_q.push_back(row.has_word ? row.word : want);
		end
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (code_word_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result pattern %0d length %0d", $time,
					m_axis_tdata[4:0], m_axis_tdata[8:5]);
			end else begin
				want = code_word_q.pop_front();
				if (m_axis_tdata[4:0] !== want.pat) begin
					errors++;
					$display("%0t: bit_pattern expected %0d got %0d", $time,
						want.pat, m_axis_tdata[4:0]);
				end
				if (m_axis_tdata[8:5] !== want.len) begin
					errors++;
					$display("%0t: bit_length expected %0d got %0d", $time,
						want.len, m_axis_tdata[8:5]);
				end
			end
		end
	end

	initial begin : sink
		int stall_left;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				// long back-pressure so the encoder fills and drops s_axis_tready
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				if (stall_left == 0 && sink_stalls_on && $urandom_range(0, 99) < 25)
					stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
						: $urandom_range(1, 3);
				m_axis_tready <= (stall_left == 0);
				if (stall_left > 0) stall_left--;
			end
		end
	end

	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("[adaptive_command_code_encoder_core] ERROR");
		$finish;
	end

	initial begin : stimulus
		code_row_t row;
		int sent, seg_len, kind, nhot, hit_pct, k;
		logic [CODE_W-1:0] hot [3];
		cur_mode  = MODE_FAV3;
		fav1      = RESET_FAV1;
		fav2      = RESET_FAV2;
		fav3      = RESET_FAV3;
		since_cnt = '0;
		phase     = PHASE_FIRST;
		foreach (tally[i]) tally[i] = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_tbl[r]) send_code(dir_tbl[r]);

		// segments dominated by one to three hot codes drive every mode;
		// round-robin segments give equal counts, the rest is uniform noise
		sent = 0;
		while (sent < N_RANDOM) begin
			seg_len = $urandom_range(20, 150);
			kind    = $urandom_range(0, 9);
			nhot    = $urandom_range(1, 3);
			hit_pct = $urandom_range(30, 95);
			for (k = 0; k < 3; k++) hot[k] = CODE_W'($urandom_range(0, 31));
			src_gaps_on    = ($urandom_range(0, 3) != 0);
			sink_stalls_on = ($urandom_range(0, 3) != 0);
			for (k = 0; k < seg_len && sent < N_RANDOM; k++) begin
				row.has_word = 1'b0;
				row.word     = '0;
				if (kind < 2)
					row.code = CODE_W'($urandom_range(0, 31));
				else if (kind == 2)
					row.code = hot[k % nhot];
				else if ($urandom_range(0, 99) < hit_pct)
					row.code = $urandom_range(0, 1) ? hot[0] : hot[$urandom_range(0, nhot - 1)];
				else
					row.code = CODE_W'($urandom_range(0, 31));
				if (sent == 300) hold_req = 1'b1;
				send_code(row);
				sent++;
			end
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b0;

		while (code_word_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("[adaptive_command_code_encoder_core] OK");
		else
			$display("[adaptive_command_code_encoder_core] ERROR");
		$finish;
	end

endmodule
